FILE: rtl/mlp_sigmoid_inference_defines.svh
// ----------------------------------------------------------------------------
// mlp_sigmoid_inference_defines
// Assertion macros used by the top RTL file of the sigmoid network engine.
// ----------------------------------------------------------------------------
`ifndef MLP_SIGMOID_INFERENCE_DEFINES_SVH
`define MLP_SIGMOID_INFERENCE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MLP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MLP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/mlp_sig_pkg.sv
// ----------------------------------------------------------------------------
// mlp_sig_pkg
// Codes, default sizes and the sigmoid table entry function of the engine.
// ----------------------------------------------------------------------------
package mlp_sig_pkg;

   localparam int DEF_N_INPUTS        = 784;
   localparam int DEF_N_HIDDEN_A      = 16;
   localparam int DEF_N_HIDDEN_B      = 16;
   localparam int DEF_N_CLASSES       = 10;
   localparam int DEF_SIGMOID_ENTRIES = 256;

   typedef enum logic [1:0] {
      MODE_WEIGHT   = 2'd0,
      MODE_BIAS     = 2'd1,
      MODE_PIXEL    = 2'd2,
      MODE_CLASSIFY = 2'd3
   } mode_type;

   localparam logic [1:0] LAYER_FIRST  = 2'd0;
   localparam logic [1:0] LAYER_SECOND = 2'd1;
   localparam logic [1:0] LAYER_FINAL  = 2'd2;

   // Entry i sits at the middle of its input interval, x = -8 + step*(i + 1/2).
   // The output is 65535 * sigmoid(x), rounded half up. The sigmoid is written
   // as (1 + tanh(x/2)) / 2.
   function automatic logic [15:0] sig_entry(int i, real step);
      real x;
      real y;
      x = -8.0 + step * (real'(i) + 0.5);
      y = 32767.5 * (1.0 + $tanh(0.5 * x));
      return 16'($rtoi(y + 0.5));
   endfunction

endpackage

FILE: rtl/mlp_sig_ram.sv
// ----------------------------------------------------------------------------
// mlp_sig_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mlp_sig_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/mlp_sigmoid_inference.sv
// ----------------------------------------------------------------------------
// mlp_sigmoid_inference
// Fully connected three-layer sigmoid network with stored weights and argmax.
// ----------------------------------------------------------------------------
//  channel | direction | ports                                          | word
//  req     | in        | mode, layer_sel, neuron, source, value         | write or classify
//  rsp     | out       | guess, best_activation                         | one per classify
//
// Weight, bias and pixel words are written straight into their stores when taken.
// A classify word reads one weight from the weight RAM per cycle, plus a short
// drain and activation step for each neuron.
// After reset a clearing pass zeroes every pixel RAM entry; no word is taken
// meanwhile. A result waiting on rsp stalls only the end of the next classify.
module mlp_sigmoid_inference #(
   parameter int N_INPUTS        = mlp_sig_pkg::DEF_N_INPUTS,
   parameter int N_HIDDEN_A      = mlp_sig_pkg::DEF_N_HIDDEN_A,
   parameter int N_HIDDEN_B      = mlp_sig_pkg::DEF_N_HIDDEN_B,
   parameter int N_CLASSES       = mlp_sig_pkg::DEF_N_CLASSES,
   parameter int SIGMOID_ENTRIES = mlp_sig_pkg::DEF_SIGMOID_ENTRIES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic [1:0]         req_layer_sel,
   input  logic [3:0]         req_neuron,
   input  logic [9:0]         req_source,
   input  logic signed [15:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_guess,
   output logic [15:0]        rsp_best_activation
);

`include "mlp_sigmoid_inference_defines.svh"

   localparam int N_BIASES  = N_HIDDEN_A + N_HIDDEN_B + N_CLASSES;
   localparam int W_OFF_B   = N_HIDDEN_A * N_INPUTS;
   localparam int W_OFF_C   = W_OFF_B + N_HIDDEN_B * N_HIDDEN_A;
   localparam int W_DEPTH   = W_OFF_C + N_CLASSES * N_HIDDEN_B;
   localparam int WA_W      = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
   localparam int PIX_AW    = (N_INPUTS > 1) ? $clog2(N_INPUTS) : 1;
   localparam int BI_W      = $clog2(N_BIASES);
   localparam int MAX_FAN_AB = (N_HIDDEN_A > N_HIDDEN_B) ? N_HIDDEN_A : N_HIDDEN_B;
   localparam int MAX_FAN   = (N_INPUTS > MAX_FAN_AB) ? N_INPUTS : MAX_FAN_AB;
   localparam int SRC_W     = $clog2(MAX_FAN + 1);
   localparam int MAX_NRN_AB = (N_HIDDEN_A > N_HIDDEN_B) ? N_HIDDEN_A : N_HIDDEN_B;
   localparam int MAX_NRN   = (N_CLASSES > MAX_NRN_AB) ? N_CLASSES : MAX_NRN_AB;
   localparam int NRN_W     = $clog2(MAX_NRN + 1);
   localparam int ACC_W     = 34 + $clog2(MAX_FAN + 1);
   localparam int PRE_W     = ACC_W - 16;
   localparam int IDX_W     = $clog2(SIGMOID_ENTRIES);
   localparam int SCL_W     = 16 + $clog2(SIGMOID_ENTRIES + 1);
   localparam int CLR_W     = $clog2(N_INPUTS + 1);
   localparam real SIG_STEP = 16.0 / SIGMOID_ENTRIES;
   localparam logic signed [PRE_W-1:0] PRE_MAX = PRE_W'(32767);
   localparam logic signed [PRE_W-1:0] PRE_MIN = -PRE_W'(32768);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_RUN, S_DRAIN, S_ACT, S_LUT, S_DONE
   } state_type;

   state_type           state_ff;
   logic [CLR_W-1:0]    clr_ff;
   logic [1:0]          layer_ff;
   logic [NRN_W-1:0]    n_ff;
   logic [SRC_W-1:0]    s_ff;
   logic [WA_W-1:0]     w_addr_ff;
   logic [BI_W-1:0]     bi_ff;
   logic                v1_ff;
   logic                v2_ff;
   logic signed [32:0]  prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [15:0]  pre_ff;
   logic [NRN_W-1:0]    guess_ff;
   logic [15:0]         best_ff;
   logic                rsp_valid_ff;
   logic [3:0]          rsp_guess_ff;
   logic [15:0]         rsp_best_ff;

   // RAM ports
   logic                w_wr_en;
   logic [WA_W-1:0]     w_wr_addr;
   logic [15:0]         w_rd_data;
   logic                b_wr_en;
   logic [BI_W-1:0]     b_wr_addr;
   logic [15:0]         b_rd_data;
   logic                p_wr_en;
   logic [PIX_AW-1:0]   p_wr_addr;
   logic [7:0]          p_wr_data;
   logic [7:0]          p_rd_data;
   logic                a_wr_en;
   logic [BI_W-1:0]     a_rd_addr;
   logic [15:0]         a_rd_data;

   logic                accept;
   logic                issue;
   logic [SRC_W-1:0]    fan;
   logic [NRN_W-1:0]    n_count;
   logic [15:0]         src_act;
   logic signed [ACC_W-1:0] sum;
   logic signed [PRE_W-1:0] pre_wide;
   logic [15:0]         off_u;
   logic [SCL_W-1:0]    scl;
   logic [IDX_W-1:0]    idx;
   logic [15:0]         act;
   logic [15:0]         sig_rom [SIGMOID_ENTRIES];

   for (genvar g = 0; g < SIGMOID_ENTRIES; g++) begin : g_sig
      assign sig_rom[g] = mlp_sig_pkg::sig_entry(g, SIG_STEP);
   end

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign issue     = (state_ff == S_RUN);

   always_comb begin
      unique case (layer_ff)
         mlp_sig_pkg::LAYER_FIRST: begin
            fan     = SRC_W'(N_INPUTS);
            n_count = NRN_W'(N_HIDDEN_A);
            src_act = {p_rd_data, p_rd_data};
         end
         mlp_sig_pkg::LAYER_SECOND: begin
            fan     = SRC_W'(N_HIDDEN_A);
            n_count = NRN_W'(N_HIDDEN_B);
            src_act = a_rd_data;
         end
         default: begin
            fan     = SRC_W'(N_HIDDEN_B);
            n_count = NRN_W'(N_CLASSES);
            src_act = a_rd_data;
         end
      endcase
   end

   // Write side of the stores, decoded straight from the request word.
   always_comb begin
      w_wr_en   = 1'b0;
      w_wr_addr = '0;
      b_wr_en   = 1'b0;
      b_wr_addr = '0;
      unique case (req_layer_sel)
         mlp_sig_pkg::LAYER_FIRST: begin
            w_wr_en   = 32'(req_neuron) < 32'(N_HIDDEN_A) && 32'(req_source) < 32'(N_INPUTS);
            w_wr_addr = WA_W'(32'(req_neuron) * N_INPUTS + 32'(req_source));
            b_wr_en   = 32'(req_neuron) < 32'(N_HIDDEN_A);
            b_wr_addr = BI_W'(req_neuron);
         end
         mlp_sig_pkg::LAYER_SECOND: begin
            w_wr_en   = 32'(req_neuron) < 32'(N_HIDDEN_B) && 32'(req_source) < 32'(N_HIDDEN_A);
            w_wr_addr = WA_W'(W_OFF_B + 32'(req_neuron) * N_HIDDEN_A + 32'(req_source));
            b_wr_en   = 32'(req_neuron) < 32'(N_HIDDEN_B);
            b_wr_addr = BI_W'(N_HIDDEN_A + 32'(req_neuron));
         end
         mlp_sig_pkg::LAYER_FINAL: begin
            w_wr_en   = 32'(req_neuron) < 32'(N_CLASSES) && 32'(req_source) < 32'(N_HIDDEN_B);
            w_wr_addr = WA_W'(W_OFF_C + 32'(req_neuron) * N_HIDDEN_B + 32'(req_source));
            b_wr_en   = 32'(req_neuron) < 32'(N_CLASSES);
            b_wr_addr = BI_W'(N_HIDDEN_A + N_HIDDEN_B + 32'(req_neuron));
         end
         default: begin
            w_wr_en = 1'b0;
            b_wr_en = 1'b0;
         end
      endcase
      w_wr_en = w_wr_en && accept && (req_mode == mlp_sig_pkg::MODE_WEIGHT);
      b_wr_en = b_wr_en && accept && (req_mode == mlp_sig_pkg::MODE_BIAS);
   end

   always_comb begin
      if (state_ff == S_CLEAR) begin
         p_wr_en   = 1'b1;
         p_wr_addr = clr_ff[PIX_AW-1:0];
         p_wr_data = '0;
      end else begin
         p_wr_en   = accept && (req_mode == mlp_sig_pkg::MODE_PIXEL) &&
                     32'(req_source) < 32'(N_INPUTS);
         p_wr_addr = PIX_AW'(req_source);
         p_wr_data = req_value[7:0];
      end
   end

   assign a_rd_addr = (layer_ff == mlp_sig_pkg::LAYER_FINAL) ?
                      BI_W'(32'(s_ff) + N_HIDDEN_A) : BI_W'(s_ff);
   assign a_wr_en   = (state_ff == S_LUT);

   // Activation: bias add, floor shift to Q.12, saturation, table index.
   assign sum      = acc_ff + (ACC_W'(signed'(b_rd_data)) <<< 16);
   assign pre_wide = PRE_W'(sum >>> 16);
   assign off_u    = {~pre_ff[15], pre_ff[14:0]};
   assign scl      = SCL_W'(off_u) * SCL_W'(SIGMOID_ENTRIES);
   assign idx      = scl[16 +: IDX_W];
   assign act      = sig_rom[idx];

   mlp_sig_ram #(.WIDTH(16), .DEPTH(W_DEPTH)) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr (w_wr_addr),
      .wr_data (req_value),
      .rd_addr (w_addr_ff),
      .rd_data (w_rd_data)
   );

   mlp_sig_ram #(.WIDTH(16), .DEPTH(N_BIASES)) u_bias_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (b_wr_addr),
      .wr_data (req_value),
      .rd_addr (bi_ff),
      .rd_data (b_rd_data)
   );

   mlp_sig_ram #(.WIDTH(8), .DEPTH(N_INPUTS)) u_pixel_ram (
      .clock   (clock),
      .wr_en   (p_wr_en),
      .wr_addr (p_wr_addr),
      .wr_data (p_wr_data),
      .rd_addr (s_ff[PIX_AW-1:0]),
      .rd_data (p_rd_data)
   );

   mlp_sig_ram #(.WIDTH(16), .DEPTH(N_BIASES)) u_act_ram (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (bi_ff),
      .wr_data (act),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   always_ff @(posedge clock) begin
      prod_ff <= signed'(w_rd_data) * signed'({1'b0, src_act});
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         layer_ff     <= mlp_sig_pkg::LAYER_FIRST;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
         if (v2_ff) begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
         // The done step loads a new word itself, so the clear stays out of it.
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == CLR_W'(N_INPUTS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept && req_mode == mlp_sig_pkg::MODE_CLASSIFY) begin
                  state_ff  <= S_RUN;
                  layer_ff  <= mlp_sig_pkg::LAYER_FIRST;
                  n_ff      <= '0;
                  s_ff      <= '0;
                  w_addr_ff <= '0;
                  bi_ff     <= '0;
                  acc_ff    <= '0;
                  guess_ff  <= '0;
                  best_ff   <= '0;
               end
            end
            S_RUN: begin
               w_addr_ff <= w_addr_ff + 1'b1;
               s_ff      <= s_ff + 1'b1;
               if (s_ff == fan - 1'b1) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               if (!v1_ff && !v2_ff) begin
                  state_ff <= S_ACT;
               end
            end
            S_ACT: begin
               if (pre_wide > PRE_MAX) begin
                  pre_ff <= 16'sh7fff;
               end else if (pre_wide < PRE_MIN) begin
                  pre_ff <= -16'sh8000;
               end else begin
                  pre_ff <= pre_wide[15:0];
               end
               state_ff <= S_LUT;
            end
            S_LUT: begin
               if (layer_ff == mlp_sig_pkg::LAYER_FINAL && act > best_ff) begin
                  best_ff  <= act;
                  guess_ff <= n_ff;
               end
               bi_ff  <= bi_ff + 1'b1;
               s_ff   <= '0;
               acc_ff <= '0;
               if (n_ff == n_count - 1'b1) begin
                  n_ff <= '0;
                  if (layer_ff == mlp_sig_pkg::LAYER_FINAL) begin
                     state_ff <= S_DONE;
                  end else begin
                     layer_ff <= layer_ff + 1'b1;
                     state_ff <= S_RUN;
                  end
               end else begin
                  n_ff     <= n_ff + 1'b1;
                  state_ff <= S_RUN;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_guess_ff <= 4'(guess_ff);
                  rsp_best_ff  <= best_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_guess           = rsp_guess_ff;
   assign rsp_best_activation = rsp_best_ff;

   `MLP_ASSERT_NOW(a_pipe_in_compute, clock, reset, v2_ff, (state_ff == S_RUN || state_ff == S_DRAIN), "multiply pipeline busy outside a dot product")
   `MLP_ASSERT_NEXT(a_classify_starts, clock, reset, accept && req_mode == mlp_sig_pkg::MODE_CLASSIFY, state_ff == S_RUN, "classify word did not start the forward pass")
   `MLP_ASSERT_NOW(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_DONE), "result raised outside the done step")
   `MLP_ASSERT_NOW(a_guess_range, clock, reset, rsp_valid_ff, 32'(rsp_guess_ff) < 32'(N_CLASSES), "guess beyond the class count")

endmodule
